// ----- design/lmbx_pkg.sv -----
// Shared types and constants of the latency-matched bypass crossfade.
// No dependencies; every other file of the block but lmbx_ram imports this package.
package lmbx_pkg;

    typedef logic signed [23:0] sample_t;
    typedef logic        [16:0] gain_t;
    typedef logic signed [17:0] step_t;
    typedef logic        [24:0] recip_t;
    typedef logic        [10:0] dlen_t;

    typedef enum logic
    {
        REG_DELAY_LENGTH = 1'b0,
        REG_FADE_RECIP   = 1'b1
    } lmbx_reg_t;

    localparam logic CMD_SAMPLE = 1'b0;
    localparam logic CMD_SET    = 1'b1;

    localparam gain_t   GAIN_ONE    = 17'd65536;
    localparam gain_t   GAIN_ZERO   = 17'd0;
    localparam recip_t  RECIP_ONE   = 25'h100_0000;
    localparam recip_t  RECIP_MIN   = 25'd1;
    localparam recip_t  RECIP_RESET = 25'd34953;
    localparam dlen_t   DLEN_RESET  = 11'd0;
    localparam sample_t SAMPLE_MAX  = 24'sh7F_FFFF;
    localparam sample_t SAMPLE_MIN  = -24'sh80_0000;

    typedef struct packed
    {
        logic s1_load;
        logic s2_load;
        logic s3_load;
    } lmbx_pipe_t;

endpackage

// ----- design/lmbx_in_if.sv -----
// Input beat channel: one command, or a dry and a wet stereo sample pair, per beat.
// Depends on lmbx_pkg for the sample type.
interface lmbx_in_if import lmbx_pkg::*; ();
    logic    valid;
    logic    ready;
    logic    cmd;
    logic    bypass_on;
    sample_t dry_left;
    sample_t dry_right;
    sample_t wet_left;
    sample_t wet_right;

    modport source (output valid, cmd, bypass_on, dry_left, dry_right, wet_left, wet_right,
                    input ready);
    modport sink   (input valid, cmd, bypass_on, dry_left, dry_right, wet_left, wet_right,
                    output ready);
endinterface

// ----- design/lmbx_out_if.sv -----
// Output beat channel: one crossfaded stereo sample pair per beat.
// Depends on lmbx_pkg for the sample type.
interface lmbx_out_if import lmbx_pkg::*; ();
    logic    valid;
    logic    ready;
    sample_t mix_left;
    sample_t mix_right;

    modport source (output valid, mix_left, mix_right, input ready);
    modport sink   (input valid, mix_left, mix_right, output ready);
endinterface

// ----- design/latency_matched_bypass_crossfade.sv -----
// Top level of the latency-matched bypass crossfade: APB registers, pipeline control.
// Depends on lmbx_pkg, lmbx_in_if, lmbx_out_if, lmbx_delay, lmbx_gain and lmbx_mix.
//
// Usage
//   in_ch carries one beat per item: cmd CMD_SAMPLE brings a dry and a wet stereo pair,
//   cmd CMD_SET sets bypass on or off and restarts the gain ramp toward 0 or unity.
//   out_ch carries one crossfaded stereo pair for every sample beat; set beats give none.
//   The APB port holds delay_length (address 0) and fade_reciprocal (address 4);
//   write it only while the block is empty.
// Pipeline and throughput
//   A sample beat passes the stages in order: delay RAM read at the accepting edge,
//   gain product per channel, round and saturate into the output register.
//   One beat per cycle is taken while out_ch does not stall; the single 18x25 multiplier per
//   channel per stage and the one-port-per-cycle ring RAMs set that rate.
// Reset
//   Gain returns to unity with target on, the ring position and fill count to zero; ring
//   entries not yet written since reset read as zero, so no clearing pass is needed.
// Back-pressure
//   When out_ch stalls, the output register holds its beat and the stages behind it keep
//   filling; in_ch.ready drops only once all three stages are occupied.
module latency_matched_bypass_crossfade import lmbx_pkg::*; #(
    parameter int MAX_DELAY = 1024
) (
    input  logic        clk,
    input  logic        rst_n,
    lmbx_in_if.sink     in_ch,
    lmbx_out_if.source  out_ch,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    dlen_t      delay_length_reg;
    recip_t     fade_recip_reg;
    lmbx_reg_t  reg_sel;
    logic       cfg_wr;
    logic       len_wr;

    logic       s1_v_reg;
    logic       s2_v_reg;
    logic       s3_v_reg;
    logic       s1_free;
    logic       s2_free;
    logic       s3_free;
    logic       sample_acc;
    logic       set_acc;
    lmbx_pipe_t pipe;

    gain_t      gain_s1;
    sample_t    dly_left;
    sample_t    dly_right;

    assign pready  = 1'b1;
    assign reg_sel = lmbx_reg_t'(paddr[2]);
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign len_wr  = cfg_wr && (reg_sel == REG_DELAY_LENGTH);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delay_length_reg <= DLEN_RESET;
            fade_recip_reg   <= RECIP_RESET;
        end
        else if (cfg_wr)
        begin
            case (reg_sel)
                REG_DELAY_LENGTH: delay_length_reg <= pwdata[10:0];
                REG_FADE_RECIP:   fade_recip_reg   <= pwdata[24:0];
                default:          delay_length_reg <= delay_length_reg;
            endcase
        end
    end

    always_comb
    begin
        case (reg_sel)
            REG_DELAY_LENGTH: prdata = {21'd0, delay_length_reg};
            REG_FADE_RECIP:   prdata = {7'd0, fade_recip_reg};
            default:          prdata = '0;
        endcase
    end

    assign s3_free    = !s3_v_reg || out_ch.ready;
    assign s2_free    = !s2_v_reg || s3_free;
    assign s1_free    = !s1_v_reg || s2_free;
    assign in_ch.ready = s1_free;

    assign sample_acc = in_ch.valid && s1_free && (in_ch.cmd == CMD_SAMPLE);
    assign set_acc    = in_ch.valid && s1_free && (in_ch.cmd == CMD_SET);

    assign pipe.s1_load = sample_acc;
    assign pipe.s2_load = s1_v_reg && s2_free;
    assign pipe.s3_load = s2_v_reg && s3_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg <= 1'b0;
            s2_v_reg <= 1'b0;
            s3_v_reg <= 1'b0;
        end
        else
        begin
            if (s1_free)
            begin
                s1_v_reg <= sample_acc;
            end
            if (s2_free)
            begin
                s2_v_reg <= s1_v_reg;
            end
            if (s3_free)
            begin
                s3_v_reg <= s2_v_reg;
            end
        end
    end

    lmbx_gain u_gain (
        .clk        (clk),
        .rst_n      (rst_n),
        .fade_recip (fade_recip_reg),
        .set_acc    (set_acc),
        .bypass_on  (in_ch.bypass_on),
        .sample_acc (sample_acc),
        .gain_s1    (gain_s1)
    );

    lmbx_delay #(.MAX_DELAY(MAX_DELAY)) u_delay (
        .clk          (clk),
        .rst_n        (rst_n),
        .delay_length (delay_length_reg),
        .len_wr       (len_wr),
        .sample_acc   (sample_acc),
        .dry_left     (in_ch.dry_left),
        .dry_right    (in_ch.dry_right),
        .dly_left     (dly_left),
        .dly_right    (dly_right)
    );

    lmbx_mix u_mix_left (
        .clk     (clk),
        .pipe    (pipe),
        .wet     (in_ch.wet_left),
        .dly     (dly_left),
        .gain_s1 (gain_s1),
        .mix     (out_ch.mix_left)
    );

    lmbx_mix u_mix_right (
        .clk     (clk),
        .pipe    (pipe),
        .wet     (in_ch.wet_right),
        .dly     (dly_right),
        .gain_s1 (gain_s1),
        .mix     (out_ch.mix_right)
    );

    assign out_ch.valid = s3_v_reg;

    a_ready_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
        !s3_v_reg |-> in_ch.ready)
        else $error("input blocked with empty output register");

endmodule

// ----- design/lmbx_ram.sv -----
// Generic single-write, single-read RAM with registered, read-first output.
// No dependencies.
module lmbx_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 1024
) (
    input  logic                                        clk,
    input  logic                                        we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                            wdata,
    input  logic                                        re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                            rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- design/lmbx_delay.sv -----
// Dry-path delay ring: position counter, fill count and two sample RAMs.
// Depends on lmbx_pkg and lmbx_ram.
module lmbx_delay import lmbx_pkg::*; #(
    parameter int MAX_DELAY = 1024
) (
    input  logic    clk,
    input  logic    rst_n,
    input  dlen_t   delay_length,
    input  logic    len_wr,
    input  logic    sample_acc,
    input  sample_t dry_left,
    input  sample_t dry_right,
    output sample_t dly_left,
    output sample_t dly_right
);

    localparam int AW = (MAX_DELAY > 1) ? $clog2(MAX_DELAY) : 1;
    localparam int CW = $clog2(MAX_DELAY + 1);

    logic [AW-1:0] pos_reg;
    logic [CW-1:0] fill_reg;
    logic [CW-1:0] len_eff;
    logic [CW-1:0] pos_plus;
    logic          ring_on;
    logic          ring_we;
    logic          byp_reg;
    logic          hit_reg;
    sample_t       dry_l_reg;
    sample_t       dry_r_reg;
    logic [23:0]   rd_left;
    logic [23:0]   rd_right;

    assign len_eff  = (32'(delay_length) > MAX_DELAY) ? CW'(MAX_DELAY) : CW'(delay_length);
    assign ring_on  = (len_eff != '0);
    assign ring_we  = sample_acc && ring_on;
    assign pos_plus = CW'(pos_reg) + CW'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg  <= '0;
            fill_reg <= '0;
        end
        else if (len_wr)
        begin
            pos_reg <= '0;
        end
        else if (ring_we)
        begin
            pos_reg <= (pos_plus >= len_eff) ? '0 : AW'(pos_plus);
            if (pos_plus > fill_reg)
            begin
                fill_reg <= pos_plus;
            end
        end
    end

    // hold the bypass path and the fill check beside the RAM read
    always_ff @(posedge clk)
    begin
        if (sample_acc)
        begin
            byp_reg   <= !ring_on;
            hit_reg   <= (CW'(pos_reg) < fill_reg);
            dry_l_reg <= dry_left;
            dry_r_reg <= dry_right;
        end
    end

    lmbx_ram #(.WIDTH(24), .DEPTH(MAX_DELAY)) u_ram_left (
        .clk   (clk),
        .we    (ring_we),
        .waddr (pos_reg),
        .wdata (dry_left),
        .re    (ring_we),
        .raddr (pos_reg),
        .rdata (rd_left)
    );

    lmbx_ram #(.WIDTH(24), .DEPTH(MAX_DELAY)) u_ram_right (
        .clk   (clk),
        .we    (ring_we),
        .waddr (pos_reg),
        .wdata (dry_right),
        .re    (ring_we),
        .raddr (pos_reg),
        .rdata (rd_right)
    );

    assign dly_left  = byp_reg ? dry_l_reg : (hit_reg ? sample_t'(rd_left)  : '0);
    assign dly_right = byp_reg ? dry_r_reg : (hit_reg ? sample_t'(rd_right) : '0);

    a_pos_in_ring: assert property (@(posedge clk) disable iff (!rst_n)
        ring_on |-> (CW'(pos_reg) < len_eff))
        else $error("ring position beyond delay length");

endmodule

// ----- design/lmbx_gain.sv -----
// Gain ramp: target, signed step and clamped gain, stepped once per sample beat.
// Depends on lmbx_pkg.
module lmbx_gain import lmbx_pkg::*; (
    input  logic   clk,
    input  logic   rst_n,
    input  recip_t fade_recip,
    input  logic   set_acc,
    input  logic   bypass_on,
    input  logic   sample_acc,
    output gain_t  gain_s1
);

    gain_t              gain_reg;
    step_t              step_reg;
    logic               target_on_reg;
    gain_t              gain_s1_reg;

    recip_t             recip_eff;
    gain_t              set_target;
    logic signed [17:0] diff;
    logic [16:0]        abs_diff;
    logic [41:0]        step_prod;
    logic [41:0]        step_rnd;
    logic [17:0]        mag;
    step_t              step_set;

    gain_t              cur_target;
    logic signed [18:0] gain_sum;
    logic signed [18:0] target_wide;
    logic               reached;
    gain_t              gain_upd;
    step_t              step_upd;

    always_comb
    begin
        if (fade_recip == '0)
        begin
            recip_eff = RECIP_MIN;
        end
        else if (fade_recip > RECIP_ONE)
        begin
            recip_eff = RECIP_ONE;
        end
        else
        begin
            recip_eff = fade_recip;
        end
    end

    assign set_target = bypass_on ? GAIN_ZERO : GAIN_ONE;
    assign diff       = $signed({1'b0, set_target}) - $signed({1'b0, gain_reg});
    assign abs_diff   = diff[17] ? 17'(-diff) : 17'(diff);
    assign step_prod  = abs_diff * recip_eff;
    assign step_rnd   = step_prod + 42'd8388608;

    always_comb
    begin
        mag = step_rnd[41:24];
        if (mag == '0)
        begin
            mag = 18'd1;
        end
        if (diff == '0)
        begin
            step_set = '0;
        end
        else if (diff[17])
        begin
            step_set = -$signed(mag);
        end
        else
        begin
            step_set = $signed(mag);
        end
    end

    assign cur_target  = target_on_reg ? GAIN_ONE : GAIN_ZERO;
    assign target_wide = $signed({2'b00, cur_target});
    assign gain_sum    = $signed({2'b00, gain_reg}) + $signed({step_reg[17], step_reg});

    always_comb
    begin
        reached = ((step_reg > 0) && (gain_sum >= target_wide))
               || ((step_reg < 0) && (gain_sum <= target_wide));
        if (step_reg == '0)
        begin
            gain_upd = gain_reg;
            step_upd = step_reg;
        end
        else if (reached)
        begin
            gain_upd = cur_target;
            step_upd = '0;
        end
        else
        begin
            gain_upd = gain_sum[16:0];
            step_upd = step_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg      <= GAIN_ONE;
            step_reg      <= '0;
            target_on_reg <= 1'b1;
        end
        else if (set_acc)
        begin
            target_on_reg <= !bypass_on;
            step_reg      <= step_set;
        end
        else if (sample_acc)
        begin
            gain_reg <= gain_upd;
            step_reg <= step_upd;
        end
    end

    always_ff @(posedge clk)
    begin
        if (sample_acc)
        begin
            gain_s1_reg <= gain_upd;
        end
    end

    assign gain_s1 = gain_s1_reg;

    a_gain_range: assert property (@(posedge clk) disable iff (!rst_n)
        gain_reg <= GAIN_ONE)
        else $error("gain above unity");

    a_idle_at_target: assert property (@(posedge clk) disable iff (!rst_n)
        (gain_reg == cur_target) |-> (step_reg == '0))
        else $error("step left running at target");

    a_step_direction: assert property (@(posedge clk) disable iff (!rst_n)
        (step_reg != '0) |-> (step_reg[17] == !target_on_reg))
        else $error("step points away from target");

endmodule

// ----- design/lmbx_mix.sv -----
// One channel of the crossfade: gain product, rounding and saturation.
// Depends on lmbx_pkg.
module lmbx_mix import lmbx_pkg::*; (
    input  logic       clk,
    input  lmbx_pipe_t pipe,
    input  sample_t    wet,
    input  sample_t    dly,
    input  gain_t      gain_s1,
    output sample_t    mix
);

    sample_t            wet_reg;
    logic signed [24:0] diff;
    logic signed [17:0] gain_sgn;
    logic signed [42:0] prod;
    logic signed [42:0] prod_reg;
    sample_t            dry2_reg;
    logic signed [42:0] prod_rnd;
    logic signed [26:0] scaled;
    logic signed [27:0] sum;
    sample_t            mix_next;
    sample_t            mix_reg;

    assign diff     = {wet_reg[23], wet_reg} - {dly[23], dly};
    assign gain_sgn = $signed({1'b0, gain_s1});
    assign prod     = gain_sgn * diff;

    assign prod_rnd = prod_reg + 43'sd32768;
    assign scaled   = prod_rnd[42:16];
    assign sum      = {scaled[26], scaled} + {{4{dry2_reg[23]}}, dry2_reg};

    always_comb
    begin
        if (sum > 28'sd8388607)
        begin
            mix_next = SAMPLE_MAX;
        end
        else if (sum < -28'sd8388608)
        begin
            mix_next = SAMPLE_MIN;
        end
        else
        begin
            mix_next = sum[23:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (pipe.s1_load)
        begin
            wet_reg <= wet;
        end
        if (pipe.s2_load)
        begin
            prod_reg <= prod;
            dry2_reg <= dly;
        end
        if (pipe.s3_load)
        begin
            mix_reg <= mix_next;
        end
    end

    assign mix = mix_reg;

endmodule
